>>> rtl/vpv_pkg.sv
// Package for the vertex projection and viewport mapping block.
// Holds widths, register index codes and the item structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vpv_pkg;

  localparam int unsigned IDX_W   = 24;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned PROD_W  = COEF_W + POS_W;
  localparam int unsigned SUM_W   = 44;
  localparam int unsigned DEN_W   = 40;
  localparam int unsigned HALF_W  = DEN_W / 2;
  localparam int unsigned SCALE_W = 20;
  localparam int unsigned QUO_W   = 20;
  localparam int unsigned SCR_W   = 20;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned ONE_SH  = 12;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_VP_MIN = 3'd4,
    REG_VP_MAX = 3'd5
  } vpv_reg_e;

  typedef struct packed {
    logic        [IDX_W-1:0] vertex_index;
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic signed [POS_W-1:0] vertex_z;
  } vpv_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] label_index;
    logic [SCR_W-1:0] screen_x;
    logic [SCR_W-1:0] screen_y;
  } vpv_out_t;

endpackage
`default_nettype wire

>>> rtl/vertex_project_to_viewport_top.sv
// Vertex projection: 4x4 matrix (rows 0, 1 and 3 used), frustum test, viewport map via pipelined divider.
// Depends on vpv_pkg.
// The start transfer passes six arithmetic stages, a 20-stage one-bit-per-stage divider and the
// output register before the valid_o strobe; throughput one vertex per cycle. busy stays low
// and the receiver cannot stall. cfg_ready_o stays high.
// Reset clears the valid bits, loads the identity matrix and an empty viewport.
`timescale 1ns / 1ps
`default_nettype none
module vertex_project_to_viewport_top import vpv_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire vpv_in_t              vertex_i,
  output logic                      valid_o,
  output vpv_out_t                  result_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]          cfg_data_i
);

  logic [63:0] row_q [4];
  logic [31:0] vp_min_q, vp_max_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 64'h0000_0000_0000_1000;
      row_q[1] <= 64'h0000_0000_1000_0000;
      row_q[2] <= 64'h0000_1000_0000_0000;
      row_q[3] <= 64'h1000_0000_0000_0000;
      vp_min_q <= '0;
      vp_max_q <= '0;
    end else if (cfg_valid_i) begin
      case (vpv_reg_e'(cfg_index_i))
        REG_ROW0:   row_q[0] <= cfg_data_i;
        REG_ROW1:   row_q[1] <= cfg_data_i;
        REG_ROW2:   row_q[2] <= cfg_data_i;
        REG_ROW3:   row_q[3] <= cfg_data_i;
        REG_VP_MIN: vp_min_q <= cfg_data_i[31:0];
        REG_VP_MAX: vp_max_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic [PIX_W-1:0] min_x, min_y, max_x, max_y;
  logic [PIX_W:0]   size_x, size_y;
  logic             vp_ok;
  assign min_x  = vp_min_q[15:0];
  assign min_y  = vp_min_q[31:16];
  assign max_x  = vp_max_q[15:0];
  assign max_y  = vp_max_q[31:16];
  assign size_x = {1'b0, max_x} - {1'b0, min_x};
  assign size_y = {1'b0, max_y} - {1'b0, min_y};
  assign vp_ok  = !size_x[PIX_W] && (size_x != '0) && !size_y[PIX_W] && (size_y != '0);

  // stage 1: products (rows 0, 1 and 3)
  logic                     s1_v_q;
  logic [IDX_W-1:0]         s1_idx_q;
  logic signed [PROD_W-1:0] s1_p_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= start;
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= vertex_i.vertex_index;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        logic signed [COEF_W-1:0] cf;
        logic signed [POS_W-1:0]  op;
        cf = $signed(row_q[(r == 2) ? 3 : r][16*c +: 16]);
        case (c)
          0:       op = vertex_i.vertex_x;
          1:       op = vertex_i.vertex_y;
          2:       op = vertex_i.vertex_z;
          default: op = POS_W'(1 << ONE_SH);
        endcase
        s1_p_q[r][c] <= cf * op;
      end
    end
  end

  // stage 2: dot product sums
  logic                    s2_v_q;
  logic [IDX_W-1:0]        s2_idx_q;
  logic signed [SUM_W-1:0] s2_s_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else         s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    s2_idx_q <= s1_idx_q;
    for (int r = 0; r < 3; r++) begin
      s2_s_q[r] <= SUM_W'(s1_p_q[r][0]) + SUM_W'(s1_p_q[r][1])
                 + SUM_W'(s1_p_q[r][2]) + SUM_W'(s1_p_q[r][3]);
    end
  end

  // stage 3: frustum and viewport test, numerators and denominator
  logic                    s3_v_q;
  logic [IDX_W-1:0]        s3_idx_q;
  logic [SUM_W-1:0]        s3_nx_q, s3_ny_q, s3_den_q;
  logic signed [SUM_W-1:0] cx, cy, cw;
  logic                    s3_vis;
  assign cx = s2_s_q[0];
  assign cy = s2_s_q[1];
  assign cw = s2_s_q[2];
  assign s3_vis = s2_v_q && vp_ok && (cw > 0) && (cx >= -cw) && (cx <= cw)
               && (cy >= -cw) && (cy <= cw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else         s3_v_q <= s3_vis;
  end

  always_ff @(posedge clk_i) begin
    s3_idx_q <= s2_idx_q;
    s3_nx_q  <= cx + cw;
    s3_ny_q  <= cw - cy;
    s3_den_q <= cw <<< 1;
  end

  // stage 4: bring the denominator below 2^40
  logic             s4_v_q;
  logic [IDX_W-1:0] s4_idx_q;
  logic [DEN_W-1:0] s4_nx_q, s4_ny_q, s4_den_q;
  logic [2:0]       sh;

  always_comb begin
    if (s3_den_q[43])      sh = 3'd4;
    else if (s3_den_q[42]) sh = 3'd3;
    else if (s3_den_q[41]) sh = 3'd2;
    else if (s3_den_q[40]) sh = 3'd1;
    else                   sh = 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else         s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    s4_idx_q <= s3_idx_q;
    s4_nx_q  <= DEN_W'(s3_nx_q >> sh);
    s4_ny_q  <= DEN_W'(s3_ny_q >> sh);
    s4_den_q <= DEN_W'(s3_den_q >> sh);
  end

  // stage 5: partial products of numerator and scaled size
  logic                          s5_v_q;
  logic [IDX_W-1:0]              s5_idx_q;
  logic [DEN_W-1:0]              s5_den_q;
  logic [HALF_W+SCALE_W-1:0]     s5_xh_q, s5_xl_q, s5_yh_q, s5_yl_q;
  logic [SCALE_W-1:0]            scl_x, scl_y;
  assign scl_x = {size_x[PIX_W-1:0], 4'b0};
  assign scl_y = {size_y[PIX_W-1:0], 4'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else         s5_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    s5_idx_q <= s4_idx_q;
    s5_den_q <= s4_den_q;
    s5_xh_q  <= s4_nx_q[DEN_W-1:HALF_W] * scl_x;
    s5_xl_q  <= s4_nx_q[HALF_W-1:0] * scl_x;
    s5_yh_q  <= s4_ny_q[DEN_W-1:HALF_W] * scl_y;
    s5_yl_q  <= s4_ny_q[HALF_W-1:0] * scl_y;
  end

  // stage 6: full dividend, split into start remainder and dividend tail
  localparam int unsigned DIVD_W = DEN_W + SCALE_W;
  logic [DIVD_W-1:0] nx_full, ny_full;
  assign nx_full = {s5_xh_q, {HALF_W{1'b0}}} + DIVD_W'(s5_xl_q);
  assign ny_full = {s5_yh_q, {HALF_W{1'b0}}} + DIVD_W'(s5_yl_q);

  logic             dv_v_q   [QUO_W+1];
  logic [IDX_W-1:0] dv_idx_q [QUO_W+1];
  logic [DEN_W-1:0] dv_den_q [QUO_W+1];
  logic [DEN_W-1:0] dv_rx_q  [QUO_W+1];
  logic [DEN_W-1:0] dv_ry_q  [QUO_W+1];
  logic [QUO_W-1:0] dv_tx_q  [QUO_W+1];
  logic [QUO_W-1:0] dv_ty_q  [QUO_W+1];
  logic [QUO_W-1:0] dv_qx_q  [QUO_W+1];
  logic [QUO_W-1:0] dv_qy_q  [QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else         dv_v_q[0] <= s5_v_q;
  end

  always_ff @(posedge clk_i) begin
    dv_idx_q[0] <= s5_idx_q;
    dv_den_q[0] <= s5_den_q;
    dv_rx_q[0]  <= nx_full[DIVD_W-1:QUO_W];
    dv_ry_q[0]  <= ny_full[DIVD_W-1:QUO_W];
    dv_tx_q[0]  <= nx_full[QUO_W-1:0];
    dv_ty_q[0]  <= ny_full[QUO_W-1:0];
    dv_qx_q[0]  <= '0;
    dv_qy_q[0]  <= '0;
  end

  // divider: one quotient bit per stage for both axes
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [DEN_W:0] tx, ty;
    logic           gx, gy;
    assign tx = {dv_rx_q[j], dv_tx_q[j][QUO_W-1]};
    assign ty = {dv_ry_q[j], dv_ty_q[j][QUO_W-1]};
    assign gx = tx >= {1'b0, dv_den_q[j]};
    assign gy = ty >= {1'b0, dv_den_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[j+1] <= 1'b0;
      else         dv_v_q[j+1] <= dv_v_q[j];
    end

    always_ff @(posedge clk_i) begin
      dv_idx_q[j+1] <= dv_idx_q[j];
      dv_den_q[j+1] <= dv_den_q[j];
      dv_rx_q[j+1]  <= gx ? DEN_W'(tx - {1'b0, dv_den_q[j]}) : DEN_W'(tx);
      dv_ry_q[j+1]  <= gy ? DEN_W'(ty - {1'b0, dv_den_q[j]}) : DEN_W'(ty);
      dv_tx_q[j+1]  <= dv_tx_q[j] << 1;
      dv_ty_q[j+1]  <= dv_ty_q[j] << 1;
      dv_qx_q[j+1]  <= {dv_qx_q[j][QUO_W-2:0], gx};
      dv_qy_q[j+1]  <= {dv_qy_q[j][QUO_W-2:0], gy};
    end
  end

  // output: offset and clamp at the viewport maximum
  logic [SCR_W:0] sum_x, sum_y, hi_x, hi_y;
  assign sum_x = {1'b0, min_x, 4'b0} + (SCR_W+1)'(dv_qx_q[QUO_W]);
  assign sum_y = {1'b0, min_y, 4'b0} + (SCR_W+1)'(dv_qy_q[QUO_W]);
  assign hi_x  = {1'b0, max_x, 4'b0};
  assign hi_y  = {1'b0, max_y, 4'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= dv_v_q[QUO_W];
  end

  always_ff @(posedge clk_i) begin
    result_o.label_index <= dv_idx_q[QUO_W];
    result_o.screen_x    <= (sum_x > hi_x) ? SCR_W'(hi_x) : SCR_W'(sum_x);
    result_o.screen_y    <= (sum_y > hi_y) ? SCR_W'(hi_y) : SCR_W'(sum_y);
  end

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[0] |-> (dv_rx_q[0] < dv_den_q[0] && dv_ry_q[0] < dv_den_q[0]))
    else $error("divider start remainder not below denominator");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> (s4_den_q != '0))
    else $error("zero denominator on a visible vertex");
  a_in_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.screen_x >= {min_x, 4'b0} && result_o.screen_y >= {min_y, 4'b0}))
    else $error("result below viewport minimum");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for vertex_project_to_viewport_top: directed and random vertices
// over several matrix and viewport settings, checked against an in-bench projection model.
// Depends on vpv_pkg and the RTL top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import vpv_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  vpv_in_t         vertex_i = '0;
  logic            valid_o;
  vpv_out_t        result_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0]     cfg_data_i = '0;

  // shadow copy of the block's registers
  logic [63:0] mvp [4];
  logic [31:0] vp_lo;
  logic [31:0] vp_hi;

  vpv_in_t  pending_vertices[$];
  vpv_out_t expected_points[$];
  int       gap_left = 0;
  bit       no_gaps = 1'b0;
  int       errors = 0;
  int       n_sent = 0;
  int       n_shown = 0;
  int       n_setups = 0;
  int       idle_cycles = 0;

  vertex_project_to_viewport_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .vertex_i(vertex_i),
    .valid_o(valid_o), .result_o(result_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint coef(logic [63:0] row, int col);
    logic signed [15:0] c;
    c = row[16*col +: 16];
    return longint'(c);
  endfunction

  function automatic longint row_dot(logic [63:0] row, longint x, longint y, longint z);
    return coef(row, 0) * x + coef(row, 1) * y + coef(row, 2) * z + coef(row, 3) * 4096;
  endfunction

  function automatic logic [SCR_W-1:0] screen_coord(longint lo, longint size, longint num,
                                                    longint den);
    longint frac;
    longint r;
    while (den >= (64'sd1 <<< 40)) begin
      num = num >>> 1;
      den = den >>> 1;
    end
    frac = (num * (size * 16)) / den;
    r = lo * 16 + frac;
    if (r < lo * 16) r = lo * 16;
    if (r > (lo + size) * 16) r = (lo + size) * 16;
    return r[SCR_W-1:0];
  endfunction

  function automatic bit project_vertex(vpv_in_t v, output vpv_out_t p);
    longint minx, miny, sx, sy, x, y, z, cx, cy, cw;
    minx = longint'(vp_lo[15:0]);
    miny = longint'(vp_lo[31:16]);
    sx = longint'(vp_hi[15:0]) - minx;
    sy = longint'(vp_hi[31:16]) - miny;
    p = '0;
    if (sx <= 0 || sy <= 0) return 1'b0;
    x = longint'(v.vertex_x);
    y = longint'(v.vertex_y);
    z = longint'(v.vertex_z);
    cx = row_dot(mvp[0], x, y, z);
    cy = row_dot(mvp[1], x, y, z);
    cw = row_dot(mvp[3], x, y, z);
    if (cw <= 0) return 1'b0;
    if (cx < -cw || cx > cw || cy < -cw || cy > cw) return 1'b0;
    p.label_index = v.vertex_index;
    p.screen_x = screen_coord(minx, sx, cx + cw, 2 * cw);
    p.screen_y = screen_coord(miny, sy, cw - cy, 2 * cw);
    return 1'b1;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    vpv_out_t p;
    if (rst_ni) begin
      if (start && !busy) begin
        n_sent++;
        if (project_vertex(vertex_i, p)) expected_points = {expected_points, p};
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          start <= 1'b1;
          vertex_i <= pending_vertices.pop_front();
          gap_left = next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vpv_out_t e;
    if (rst_ni && valid_o) begin
      n_shown++;
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $time, result_o);
      end else begin
        e = expected_points.pop_front();
        if (result_o.label_index !== e.label_index) begin
          errors++;
          $display("%0t: label_index expected %h actual %h", $time, e.label_index,
                   result_o.label_index);
        end
        if (result_o.screen_x !== e.screen_x) begin
          errors++;
          $display("%0t: screen_x expected %h actual %h", $time, e.screen_x, result_o.screen_x);
        end
        if (result_o.screen_y !== e.screen_y) begin
          errors++;
          $display("%0t: screen_y expected %h actual %h", $time, e.screen_y, result_o.screen_y);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("[vertex_project_to_viewport_top] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(vpv_reg_e r, logic [63:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_ROW0:   mvp[0] = d;
      REG_ROW1:   mvp[1] = d;
      REG_ROW2:   mvp[2] = d;
      REG_ROW3:   mvp[3] = d;
      REG_VP_MIN: vp_lo = d[31:0];
      REG_VP_MAX: vp_hi = d[31:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_vertices.size() != 0 || start || expected_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pack4(int c0, int c1, int c2, int c3);
    return {c3[15:0], c2[15:0], c1[15:0], c0[15:0]};
  endfunction

  function automatic int rand_coef();
    return $urandom_range(0, 8191) - 4096;
  endfunction

  task automatic send(int idx, int x, int y, int z);
    vpv_in_t v;
    v.vertex_index = idx[23:0];
    v.vertex_x = x[23:0];
    v.vertex_y = y[23:0];
    v.vertex_z = z[23:0];
    pending_vertices = {pending_vertices, v};
  endtask

  task automatic random_setup();
    int s;
    int mode;
    int mx, my;
    mode = $urandom_range(0, 3);
    s = $urandom_range(1024, 8192);
    case (mode)
      0: begin
        write_reg(REG_ROW0, pack4(s, 0, 0, rand_coef() / 8));
        write_reg(REG_ROW1, pack4(0, s, 0, rand_coef() / 8));
        write_reg(REG_ROW3, pack4(0, 0, 0, $urandom_range(2048, 8192)));
      end
      1: begin
        write_reg(REG_ROW0, pack4(s, 0, rand_coef() / 4, 0));
        write_reg(REG_ROW1, pack4(0, s, rand_coef() / 4, 0));
        write_reg(REG_ROW3, pack4(0, 0, -4096, $urandom_range(0, 1024)));
      end
      2: begin
        write_reg(REG_ROW0, pack4(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
        write_reg(REG_ROW1, pack4(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
        write_reg(REG_ROW3, pack4(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
      end
      default: begin
        write_reg(REG_ROW0, {$urandom, $urandom});
        write_reg(REG_ROW1, {$urandom, $urandom});
        write_reg(REG_ROW3, {$urandom, $urandom});
      end
    endcase
    write_reg(REG_ROW2, {$urandom, $urandom});
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      write_reg(REG_VP_MIN, 64'h0);
      write_reg(REG_VP_MAX, 64'hFFFF_FFFF);
    end else if (mode == 1) begin
      write_reg(REG_VP_MIN, {32'h0, $urandom});
      write_reg(REG_VP_MAX, {32'h0, $urandom});
    end else begin
      mx = $urandom_range(0, 4000);
      my = $urandom_range(0, 4000);
      write_reg(REG_VP_MIN, {32'h0, my[15:0], mx[15:0]});
      mx = mx + $urandom_range(1, 3000);
      my = my + $urandom_range(1, 3000);
      write_reg(REG_VP_MAX, {32'h0, my[15:0], mx[15:0]});
    end
    n_setups++;
  endtask

  initial begin
    int x, y, z;
    mvp[0] = 64'd4096;
    mvp[1] = 64'd268435456;
    mvp[2] = 64'd17592186044416;
    mvp[3] = 64'd1152921504606846976;
    vp_lo = '0;
    vp_hi = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty viewport after reset, field extremes
    send(0, 0, 0, 0);
    send(24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send(24'h5A5A5A, 24'h800000, 24'h7FFFFF, 24'h800000);
    wait_idle();

    // identity matrix, ordinary viewport: edges, inside and outside the frustum
    write_reg(REG_VP_MIN, 64'h0014_000A);
    write_reg(REG_VP_MAX, 64'h01F4_028A);
    n_setups++;
    send(1, 0, 0, 0);
    send(2, 4096, 4096, 0);
    send(3, -4096, -4096, 0);
    send(4, 4097, 0, 0);
    send(5, 0, -4097, 0);
    send(6, 4095, -4095, 24'h7FFFFF);
    send(7, 24'h7FFFFF, 0, 0);
    send(8, 24'h800000, 0, 0);
    wait_idle();

    // clip w negative, then zero
    write_reg(REG_ROW3, pack4(0, 0, 0, -4096));
    send(9, 0, 0, 0);
    wait_idle();
    write_reg(REG_ROW3, 64'h0);
    send(10, 0, 0, 0);
    wait_idle();

    // largest coefficients and positions: divisor beyond the shift threshold
    write_reg(REG_ROW0, pack4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    write_reg(REG_ROW1, pack4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    write_reg(REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ROW3, pack4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    write_reg(REG_VP_MIN, 64'h0);
    write_reg(REG_VP_MAX, 64'hFFFF_FFFF);
    n_setups++;
    send(11, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send(12, 24'h7FFFFF, 24'h7FFFF0, 24'h7FFFFF);
    send(13, 24'h800000, 24'h800000, 24'h800000);
    wait_idle();

    // viewport with no extent in y
    write_reg(REG_VP_MIN, 64'h0100_0000);
    write_reg(REG_VP_MAX, 64'h0100_FFFF);
    send(14, 0, 0, 4096);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      random_setup();
      no_gaps = (ph % 3 == 2);
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          send($urandom, $urandom, $urandom, $urandom);
        end else begin
          x = $signed($urandom_range(0, 12000)) - 6000;
          y = $signed($urandom_range(0, 12000)) - 6000;
          z = $signed($urandom_range(0, 16000)) - 8000;
          send($urandom, x, y, z);
        end
      end
      wait_idle();
    end

    $display("covered %0d vertices over %0d register setups, %0d points on screen",
             n_sent, n_setups, n_shown);
    if (errors == 0)
      $display("[vertex_project_to_viewport_top] OK");
    else
      $display("[vertex_project_to_viewport_top] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
